>>> design/timer_bank_oneshot_periodic_unit_macros.svh
// assertion macros shared by the timer bank rtl
`ifndef TIMER_BANK_ONESHOT_PERIODIC_UNIT_MACROS_SVH
`define TIMER_BANK_ONESHOT_PERIODIC_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication under reset
`define TBOP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication under reset
`define TBOP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TBOP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define TBOP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> design/tbop_pkg.sv
// shared types and constants of the timer bank
`default_nettype none
package tbop_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 27;
    localparam int DUR_W  = 32;

    // one day in milliseconds
    localparam logic [TIME_W-1:0] DAY_MS = 27'd86400000;

    // command codes
    localparam logic [2:0] CMD_SET        = 3'd0;
    localparam logic [2:0] CMD_CANCEL     = 3'd1;
    localparam logic [2:0] CMD_CANCEL_ALL = 3'd2;
    localparam logic [2:0] CMD_QUERY      = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BAD_ID  = 2'd1;
    localparam logic [1:0] STAT_BAD_DUR = 2'd2;

    // result kinds
    localparam logic KIND_RESP   = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // one stored timer entry
    typedef struct packed {
        logic              periodic;
        logic [TIME_W-1:0] start_ms;
        logic [TIME_W-1:0] dur_ms;
    } entry_t;

    // walk tag that travels with each entry through the pipeline
    typedef struct packed {
        logic            vld;
        logic            fin;
        logic [ID_W-1:0] idx;
    } tag_t;

endpackage
`default_nettype wire

>>> design/tbop_ram.sv
// timer entry memory with registered read
`default_nettype none
module tbop_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire tbop_pkg::entry_t wdata,
    input  wire logic [AW-1:0]    raddr,
    output tbop_pkg::entry_t      rdata
);

    tbop_pkg::entry_t mem [DEPTH];
    tbop_pkg::entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> design/tbop_eval.sv
// two-stage elapsed time and expiry compare for the tick walk
`default_nettype none
module tbop_eval (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tbop_pkg::tag_t              tag_in,
    input  wire tbop_pkg::entry_t            rdata,
    input  wire logic [tbop_pkg::TIME_W-1:0] now_ms,
    output tbop_pkg::tag_t                   tag_out,
    output tbop_pkg::entry_t                 entry_out,
    output logic                             expired
);

    localparam int TW = tbop_pkg::TIME_W;

    tbop_pkg::tag_t   tag_a_reg;
    tbop_pkg::tag_t   tag_b_reg;
    tbop_pkg::entry_t entry_b_reg;
    logic             ge_reg;
    logic [TW-1:0]    diff_reg;
    logic [TW-1:0]    back_reg;

    logic [TW:0]      fwd_diff;
    logic [TW-1:0]    back_diff;
    logic [TW:0]      wrap_sum;

    // tag follows the memory read latency, then the compute stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    // stage a: forward and backward differences
    assign fwd_diff  = {1'b0, now_ms} - {1'b0, rdata.start_ms};
    assign back_diff = rdata.start_ms - now_ms;

    always_ff @(posedge clk)
    begin
        ge_reg      <= ~fwd_diff[TW];
        diff_reg    <= fwd_diff[TW-1:0];
        back_reg    <= back_diff;
        entry_b_reg <= rdata;
    end

    // stage b: elapsed >= duration, with day wrap folded into one add
    assign wrap_sum = {1'b0, back_reg} + {1'b0, entry_b_reg.dur_ms};

    always_comb
    begin
        if (ge_reg)
        begin
            expired = (diff_reg >= entry_b_reg.dur_ms);
        end
        else
        begin
            expired = (back_reg <= tbop_pkg::DAY_MS)
                   && (wrap_sum <= {1'b0, tbop_pkg::DAY_MS});
        end
    end

    assign tag_out   = tag_b_reg;
    assign entry_out = entry_b_reg;

endmodule
`default_nettype wire

>>> design/timer_bank_oneshot_periodic_unit.sv
// timer bank top level: command decode, run flags, tick walk and result output
//
//  channel   ports                                                handshake
//  -------   --------------------------------------------------   -----------------------
//  request   command timer_sel periodic_mode duration_ms now_ms   start && !busy
//  result    result_kind result_timer status is_running last      result_valid, one cycle
//
// set, cancel, cancel all and query do not raise busy; the response shows the cycle after.
// a tick holds busy while it walks: one entry memory read per timer through
// a three-deep read/compute/decide pipeline, then a flush state releases the held event.
// expiry events appear in index order during the walk; last marks the final one.
// reset clears the run flags and control state, not the stored entries; these are read only behind a set run flag.
// the result side cannot stall; each result is valid for exactly one cycle.
`default_nettype none
`include "timer_bank_oneshot_periodic_unit_macros.svh"
module timer_bank_oneshot_periodic_unit #(
    parameter int TIMER_COUNT = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [2:0]                  command,
    input  wire logic [tbop_pkg::ID_W-1:0]   timer_sel,
    input  wire logic                        periodic_mode,
    input  wire logic [tbop_pkg::DUR_W-1:0]  duration_ms,
    input  wire logic [tbop_pkg::TIME_W-1:0] now_ms,
    output logic                             result_valid,
    output logic                             result_kind,
    output logic [tbop_pkg::ID_W-1:0]        result_timer,
    output logic [1:0]                       status,
    output logic                             is_running,
    output logic                             last
);

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W = $clog2(TIMER_COUNT + 1);
    localparam int ID_W  = tbop_pkg::ID_W;
    localparam int TW    = tbop_pkg::TIME_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [TIMER_COUNT-1:0] run_reg, run_next;
    logic [TW-1:0]          now_reg;

    logic                   pend_vld_reg, pend_vld_next;
    logic [ID_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                   pend_run_reg, pend_run_next;

    logic                   res_vld_reg, res_vld_next;
    logic                   res_kind_reg, res_kind_next;
    logic [ID_W-1:0]        res_timer_reg, res_timer_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic                   res_run_reg, res_run_next;
    logic                   res_last_reg, res_last_next;

    logic                   acc;
    logic                   id_ok;
    logic                   dur_ok;
    logic [IDX_W-1:0]       id_idx;
    logic [TW-1:0]          set_dur;
    logic                   set_we;

    logic                   issue_vld;
    logic [ID_W-1:0]        issue_idx;
    tbop_pkg::tag_t         issue_tag;

    tbop_pkg::tag_t         tag_b;
    tbop_pkg::entry_t       entry_b;
    logic                   expired;
    logic [IDX_W-1:0]       idx_b;
    logic                   hit_b;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    tbop_pkg::entry_t       ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    tbop_pkg::entry_t       ram_rdata;

    // request decode
    assign busy    = (state_reg != ST_IDLE);
    assign acc     = start && !busy;
    assign id_ok   = (timer_sel < ID_W'(TIMER_COUNT));
    assign dur_ok  = (duration_ms < {{(tbop_pkg::DUR_W - TW){1'b0}}, tbop_pkg::DAY_MS});
    assign id_idx  = timer_sel[IDX_W-1:0];
    assign set_dur = (duration_ms == '0) ? TW'(1) : duration_ms[TW-1:0];
    assign set_we  = acc && (command == tbop_pkg::CMD_SET) && id_ok && dur_ok;

    // walk issue: entry zero goes out with the tick request itself
    assign issue_vld = (acc && (command == tbop_pkg::CMD_TICK))
                    || ((state_reg == ST_WALK) && (cnt_reg < CNT_W'(TIMER_COUNT)));
    assign issue_idx = (state_reg == ST_IDLE) ? '0 : ID_W'(cnt_reg);
    assign issue_tag.vld = issue_vld;
    assign issue_tag.fin = (issue_idx == ID_W'(TIMER_COUNT - 1));
    assign issue_tag.idx = issue_idx;

    // decide stage
    assign idx_b = tag_b.idx[IDX_W-1:0];
    assign hit_b = tag_b.vld && run_reg[idx_b] && expired;

    // memory write port: set when idle, periodic reload during the walk
    always_comb
    begin
        if (busy)
        begin
            ram_we             = hit_b && entry_b.periodic;
            ram_waddr          = idx_b;
            ram_wdata          = entry_b;
            ram_wdata.start_ms = now_reg;
        end
        else
        begin
            ram_we             = set_we;
            ram_waddr          = id_idx;
            ram_wdata.periodic = periodic_mode;
            ram_wdata.start_ms = now_ms;
            ram_wdata.dur_ms   = set_dur;
        end
    end

    assign ram_raddr = issue_idx[IDX_W-1:0];

    tbop_ram #(
        .DEPTH (TIMER_COUNT),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tbop_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag_in    (issue_tag),
        .rdata     (ram_rdata),
        .now_ms    (now_reg),
        .tag_out   (tag_b),
        .entry_out (entry_b),
        .expired   (expired)
    );

    // control, run flags and result selection
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        run_next        = run_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        pend_run_next   = pend_run_reg;
        res_vld_next    = 1'b0;
        res_kind_next   = tbop_pkg::KIND_RESP;
        res_timer_next  = timer_sel;
        res_status_next = tbop_pkg::STAT_OK;
        res_run_next    = 1'b0;
        res_last_next   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (command)
                        tbop_pkg::CMD_SET:
                        begin
                            res_vld_next = 1'b1;
                            if (!id_ok)
                            begin
                                res_status_next = tbop_pkg::STAT_BAD_ID;
                            end
                            else if (!dur_ok)
                            begin
                                res_status_next = tbop_pkg::STAT_BAD_DUR;
                            end
                            else
                            begin
                                run_next[id_idx] = 1'b1;
                            end
                        end
                        tbop_pkg::CMD_CANCEL:
                        begin
                            res_vld_next = 1'b1;
                            if (!id_ok)
                            begin
                                res_status_next = tbop_pkg::STAT_BAD_ID;
                            end
                            else
                            begin
                                run_next[id_idx] = 1'b0;
                            end
                        end
                        tbop_pkg::CMD_CANCEL_ALL:
                        begin
                            res_vld_next   = 1'b1;
                            res_timer_next = '0;
                            run_next       = '0;
                        end
                        tbop_pkg::CMD_QUERY:
                        begin
                            res_vld_next = 1'b1;
                            if (!id_ok)
                            begin
                                res_status_next = tbop_pkg::STAT_BAD_ID;
                            end
                            else
                            begin
                                res_run_next = run_reg[id_idx];
                            end
                        end
                        tbop_pkg::CMD_TICK:
                        begin
                            state_next    = ST_WALK;
                            cnt_next      = CNT_W'(1);
                            pend_vld_next = 1'b0;
                        end
                        default:
                        begin
                            res_vld_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (cnt_reg < CNT_W'(TIMER_COUNT))
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                // an expired timer releases the held event and takes its place
                if (hit_b)
                begin
                    if (!entry_b.periodic)
                    begin
                        run_next[idx_b] = 1'b0;
                    end
                    res_vld_next    = pend_vld_reg;
                    res_kind_next   = tbop_pkg::KIND_EXPIRY;
                    res_timer_next  = pend_idx_reg;
                    res_run_next    = pend_run_reg;
                    res_last_next   = 1'b0;
                    pend_vld_next   = 1'b1;
                    pend_idx_next   = tag_b.idx;
                    pend_run_next   = entry_b.periodic;
                end
                if (tag_b.vld && tag_b.fin)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                res_vld_next   = pend_vld_reg;
                res_kind_next  = tbop_pkg::KIND_EXPIRY;
                res_timer_next = pend_idx_reg;
                res_run_next   = pend_run_reg;
                res_last_next  = 1'b1;
                pend_vld_next  = 1'b0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            run_reg      <= '0;
            pend_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            run_reg      <= run_next;
            pend_vld_reg <= pend_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc && (command == tbop_pkg::CMD_TICK))
        begin
            now_reg <= now_ms;
        end
        pend_idx_reg   <= pend_idx_next;
        pend_run_reg   <= pend_run_next;
        res_kind_reg   <= res_kind_next;
        res_timer_reg  <= res_timer_next;
        res_status_reg <= res_status_next;
        res_run_reg    <= res_run_next;
        res_last_reg   <= res_last_next;
    end

    assign result_valid = res_vld_reg;
    assign result_kind  = res_kind_reg;
    assign result_timer = res_timer_reg;
    assign status       = res_status_reg;
    assign is_running   = res_run_reg;
    assign last         = res_last_reg;

    // checks
    `TBOP_ASSERT_NEXT(a_tick_walks, clk, rst_n, acc && (command == tbop_pkg::CMD_TICK),
        busy, "tick request did not start a walk")
    `TBOP_ASSERT_IMPL(a_resp_last, clk, rst_n,
        result_valid && (result_kind == tbop_pkg::KIND_RESP),
        last, "command response without last")
    `TBOP_ASSERT_IMPL(a_event_idx, clk, rst_n,
        result_valid && (result_kind == tbop_pkg::KIND_EXPIRY),
        result_timer < ID_W'(TIMER_COUNT), "expiry event for a timer outside the bank")
    `TBOP_ASSERT_NEXT(a_flush_ends, clk, rst_n, state_reg == ST_FLUSH,
        !busy && !pend_vld_reg, "walk did not end after the flush cycle")
    `TBOP_ASSERT_IMPL(a_walk_quiet, clk, rst_n,
        busy && (state_reg == ST_WALK) && result_valid,
        !last, "last raised before the walk ended")

endmodule
`default_nettype wire
